// ===== src/ppst_pkg.sv =====
package ppst_pkg;

    localparam int MAX_POINTS   = 256;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int PADDR_W      = 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_LOOKAHEAD = 1'b0;
    localparam logic REG_WHEELBASE = 1'b1;

    localparam logic [22:0] LOOKAHEAD_RESET = 23'd196608;
    localparam logic [19:0] WHEELBASE_RESET = 20'd98304;

    localparam logic signed [33:0] PI_Q28          = 34'sd843314857;
    localparam logic signed [33:0] HALF_PI_Q28     = 34'sd421657428;
    localparam logic signed [63:0] CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam logic signed [32:0] RAD_TO_DEG_Q16  = 33'sd3754936;
    localparam logic signed [13:0] STEER_LIMIT     = 14'sd5094;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] arc;
    } path_word_t;

    // Elementary rotation angles atan(2^-i) in Q28 radians.
    function automatic logic signed [33:0] atan_step(input int i);
        logic signed [33:0] r;
        if (i < 10) begin
            case (i)
                0:       r = 34'sd210828714;
                1:       r = 34'sd124459457;
                2:       r = 34'sd65760959;
                3:       r = 34'sd33381290;
                4:       r = 34'sd16755422;
                5:       r = 34'sd8385879;
                6:       r = 34'sd4193963;
                7:       r = 34'sd2097109;
                8:       r = 34'sd1048571;
                default: r = 34'sd524287;
            endcase
        end
        else if (i <= 28) begin
            r = 34'sd1 <<< (28 - i);
        end
        else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== src/pure_pursuit_steering_unit.sv =====
// Channel   Transfer when                       Direction  Contents
// config    psel & penable & pwrite (pready=1)  in         lookahead_distance, wheelbase
// command   start & !busy                       in         cmd, point fields, car pose
// result    done (one cycle)                    out        target point, index, steering
//
// The first point of a path is stored without raising busy; any later point that fits in
// the memory keeps busy high while the bit-serial square root of its arc step runs.
// A query keeps busy high through the nearest-point scan over all N points, the walk of W
// points to the target and, unless the target lies near the origin, three CORDIC runs;
// the single multiplier in the nearest-point scan squares both offsets of every point.
// Reset clears the counters and loads the register defaults; path memory needs no clearing.
// The result cannot be stalled: done marks it for exactly one cycle.
module pure_pursuit_steering_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppst_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic signed [31:0]           point_x,
    input  logic signed [31:0]           point_y,
    input  logic                         point_last,
    input  logic signed [31:0]           car_x,
    input  logic signed [31:0]           car_y,
    input  logic signed [15:0]           car_yaw,
    output logic                         done,
    output logic signed [31:0]           target_x,
    output logic signed [31:0]           target_y,
    output logic [7:0]                   target_index,
    output logic signed [13:0]           steering_deg,
    output logic                         no_path
);
    import ppst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_L_MX, S_L_MY, S_L_SUM, S_L_ROOT, S_L_WAIT,
        S_Q_WAIT, S_Q_ABS, S_Q_MX, S_Q_MY, S_Q_SUM,
        S_ARC_WAIT, S_ARC, S_WALK_WAIT, S_WALK,
        S_O_MX, S_O_MY, S_O_SUM,
        S_ATAN, S_ATAN_WAIT, S_SIN, S_SIN_WAIT,
        S_NUM, S_STEER, S_STEER_WAIT, S_DEG, S_DEG_WAIT
    } state_t;

    localparam logic signed [65:0] DEG_ROUND = 66'sd1 <<< 35;
    localparam logic signed [65:0] LIMIT_HI  = 66'(STEER_LIMIT);
    localparam logic signed [33:0] TWO_PI    = PI_Q28 <<< 1;

    state_t             state_reg;
    logic [22:0]        la_reg;
    logic [19:0]        wb_reg;
    logic [CNT_W-1:0]   point_count_reg;
    logic [CNT_W-1:0]   load_count_reg;
    logic signed [31:0] prev_x_reg;
    logic signed [31:0] prev_y_reg;
    logic [31:0]        prev_arc_reg;
    logic signed [31:0] lx_reg;
    logic signed [31:0] ly_reg;
    logic               last_reg;
    logic               half_reg;
    logic [31:0]        ax_reg;
    logic [31:0]        ay_reg;
    logic [64:0]        acc_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [15:0] yaw_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [ADDR_W-1:0]  best_reg;
    logic [64:0]        best_d_reg;
    logic [31:0]        base_reg;
    logic [ADDR_W-1:0]  pick_reg;
    logic signed [31:0] tx_reg;
    logic signed [31:0] ty_reg;
    logic signed [33:0] alpha_reg;
    logic signed [32:0] s_reg;
    logic signed [32:0] delta_reg;
    logic signed [13:0] deg_reg;
    logic               no_path_reg;
    logic               done_reg;

    logic               accept;
    logic [CNT_W-1:0]   k;
    logic [31:0]        lax;
    logic [31:0]        lay;
    logic               lhalf;
    path_word_t         rdata;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic [31:0]        qax;
    logic [31:0]        qay;
    logic [31:0]        rmx;
    logic [31:0]        rmy;
    logic signed [65:0] p;
    logic [64:0]        sq_sum;
    logic               closer;
    logic [ADDR_W-1:0]  nb;
    logic               root_done;
    logic [31:0]        root;
    logic [32:0]        root_ext;
    logic [33:0]        arc_sum;
    logic [31:0]        arc_new;
    logic               far;
    logic               mem_we;
    path_word_t         mem_wdata;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic               c_start;
    logic               c_vec;
    logic signed [63:0] c_x0;
    logic signed [63:0] c_y0;
    logic               c_done;
    logic signed [63:0] c_y;
    logic signed [33:0] c_z;
    logic signed [33:0] a0;
    logic signed [33:0] a1;
    logic signed [33:0] a2;
    logic signed [65:0] dsh;
    logic signed [13:0] dclamp;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = v[32] ? -v : v;
        return n[31:0];
    endfunction

    assign accept = start && (state_reg == S_IDLE);
    assign k      = load_count_reg;

    assign lax   = mag33({point_x[31], point_x} - {prev_x_reg[31], prev_x_reg});
    assign lay   = mag33({point_y[31], point_y} - {prev_y_reg[31], prev_y_reg});
    assign lhalf = lax[31] | lay[31];

    assign rx  = rdata.x;
    assign ry  = rdata.y;
    assign qax = mag33({rx[31], rx} - {cx_reg[31], cx_reg});
    assign qay = mag33({ry[31], ry} - {cy_reg[31], cy_reg});
    assign rmx = mag33({rx[31], rx});
    assign rmy = mag33({ry[31], ry});

    assign sq_sum = acc_reg + {1'b0, p[63:0]};
    assign closer = (i_reg == '0) || (sq_sum < best_d_reg);
    assign nb     = closer ? i_reg[ADDR_W-1:0] : best_reg;

    assign root_ext = half_reg ? {root, 1'b0} : {1'b0, root};
    assign arc_sum  = {2'b00, prev_arc_reg} + {1'b0, root_ext};
    assign arc_new  = (arc_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : arc_sum[31:0];

    assign far = (rdata.arc - base_reg) > {9'b0, la_reg};

    // Bearing minus heading, wrapped into (-pi, pi] and folded into [-pi/2, pi/2].
    always_comb
    begin
        a0 = c_z - {{3{yaw_reg[15]}}, yaw_reg, 15'b0};
        if (a0 > PI_Q28)
        begin
            a1 = a0 - TWO_PI;
        end
        else if (a0 <= -PI_Q28)
        begin
            a1 = a0 + TWO_PI;
        end
        else
        begin
            a1 = a0;
        end
        if (a1 > HALF_PI_Q28)
        begin
            a2 = PI_Q28 - a1;
        end
        else if (a1 < -HALF_PI_Q28)
        begin
            a2 = -PI_Q28 - a1;
        end
        else
        begin
            a2 = a1;
        end
    end

    always_comb
    begin
        dsh = (p + DEG_ROUND) >>> 36;
        if (dsh > LIMIT_HI)
        begin
            dclamp = STEER_LIMIT;
        end
        else if (dsh < -LIMIT_HI)
        begin
            dclamp = -STEER_LIMIT;
        end
        else
        begin
            dclamp = dsh[13:0];
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '{x: point_x, y: point_y, arc: 32'h0};
        if (accept && cmd == CMD_LOAD && k == '0)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_L_WAIT && root_done)
        begin
            mem_we    = 1'b1;
            mem_wdata = '{x: lx_reg, y: ly_reg, arc: arc_new};
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_L_MX, S_Q_MX, S_O_MX:
            begin
                mul_a = {1'b0, ax_reg};
                mul_b = {1'b0, ax_reg};
            end
            S_L_MY, S_Q_MY, S_O_MY:
            begin
                mul_a = {1'b0, ay_reg};
                mul_b = {1'b0, ay_reg};
            end
            S_NUM:
            begin
                mul_a = {13'b0, wb_reg};
                mul_b = s_reg;
            end
            S_DEG:
            begin
                mul_a = delta_reg;
                mul_b = RAD_TO_DEG_Q16;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        c_start = 1'b0;
        c_vec   = 1'b1;
        c_x0    = '0;
        c_y0    = '0;
        unique case (state_reg)
            S_ATAN:
            begin
                c_start = 1'b1;
                c_x0    = 64'($signed({tx_reg[31], tx_reg} - {cx_reg[31], cx_reg}));
                c_y0    = 64'($signed({ty_reg[31], ty_reg} - {cy_reg[31], cy_reg}));
            end
            S_SIN:
            begin
                c_start = 1'b1;
                c_vec   = 1'b0;
                c_x0    = CORDIC_GAIN_Q30;
            end
            S_STEER:
            begin
                c_start = 1'b1;
                c_x0    = {11'b0, la_reg, 30'b0};
                c_y0    = {p[62:0], 1'b0};
            end
            default:
            begin
                c_start = 1'b0;
            end
        endcase
    end

    ppst_path_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (k[ADDR_W-1:0]),
        .wdata (mem_wdata),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    ppst_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (p)
    );

    ppst_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_L_ROOT),
        .radicand (acc_reg[63:0]),
        .done     (root_done),
        .root     (root)
    );

    ppst_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .vec   (c_vec),
        .x0    (c_x0),
        .y0    (c_y0),
        .z0    (alpha_reg),
        .done  (c_done),
        .y     (c_y),
        .z     (c_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_reg <= LOOKAHEAD_RESET;
            wb_reg <= WHEELBASE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_LOOKAHEAD)
            begin
                la_reg <= pwdata[22:0];
            end
            else
            begin
                wb_reg <= pwdata[19:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_WHEELBASE) ? {12'b0, wb_reg} : {9'b0, la_reg};
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            load_count_reg  <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_arc_reg    <= '0;
            lx_reg          <= '0;
            ly_reg          <= '0;
            last_reg        <= 1'b0;
            half_reg        <= 1'b0;
            ax_reg          <= '0;
            ay_reg          <= '0;
            acc_reg         <= '0;
            cx_reg          <= '0;
            cy_reg          <= '0;
            yaw_reg         <= '0;
            i_reg           <= '0;
            ptr_reg         <= '0;
            best_reg        <= '0;
            best_d_reg      <= '0;
            base_reg        <= '0;
            pick_reg        <= '0;
            tx_reg          <= '0;
            ty_reg          <= '0;
            alpha_reg       <= '0;
            s_reg           <= '0;
            delta_reg       <= '0;
            deg_reg         <= '0;
            no_path_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd == CMD_LOAD)
                    begin
                        if (k < CNT_W'(MAX_POINTS))
                        begin
                            if (k == '0)
                            begin
                                prev_x_reg   <= point_x;
                                prev_y_reg   <= point_y;
                                prev_arc_reg <= '0;
                                if (point_last)
                                begin
                                    point_count_reg <= CNT_W'(1);
                                    load_count_reg  <= '0;
                                end
                                else
                                begin
                                    point_count_reg <= '0;
                                    load_count_reg  <= CNT_W'(1);
                                end
                            end
                            else
                            begin
                                lx_reg    <= point_x;
                                ly_reg    <= point_y;
                                last_reg  <= point_last;
                                half_reg  <= lhalf;
                                ax_reg    <= lhalf ? (lax >> 1) : lax;
                                ay_reg    <= lhalf ? (lay >> 1) : lay;
                                state_reg <= S_L_MX;
                            end
                        end
                        else if (point_last)
                        begin
                            point_count_reg <= load_count_reg;
                            load_count_reg  <= '0;
                        end
                    end
                    else if (accept)
                    begin
                        cx_reg  <= car_x;
                        cy_reg  <= car_y;
                        yaw_reg <= car_yaw;
                        if (point_count_reg == '0)
                        begin
                            tx_reg      <= '0;
                            ty_reg      <= '0;
                            pick_reg    <= '0;
                            deg_reg     <= '0;
                            no_path_reg <= 1'b1;
                            done_reg    <= 1'b1;
                        end
                        else
                        begin
                            no_path_reg <= 1'b0;
                            i_reg       <= '0;
                            ptr_reg     <= '0;
                            state_reg   <= S_Q_WAIT;
                        end
                    end
                end
                S_L_MX:
                begin
                    state_reg <= S_L_MY;
                end
                S_L_MY:
                begin
                    acc_reg   <= {1'b0, p[63:0]};
                    state_reg <= S_L_SUM;
                end
                S_L_SUM:
                begin
                    acc_reg   <= sq_sum;
                    state_reg <= S_L_ROOT;
                end
                S_L_ROOT:
                begin
                    state_reg <= S_L_WAIT;
                end
                S_L_WAIT:
                begin
                    if (root_done)
                    begin
                        prev_x_reg   <= lx_reg;
                        prev_y_reg   <= ly_reg;
                        prev_arc_reg <= arc_new;
                        if (last_reg)
                        begin
                            point_count_reg <= k + 1'b1;
                            load_count_reg  <= '0;
                        end
                        else
                        begin
                            load_count_reg <= k + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_Q_WAIT:
                begin
                    state_reg <= S_Q_ABS;
                end
                S_Q_ABS:
                begin
                    ax_reg    <= qax;
                    ay_reg    <= qay;
                    // Prefetch the next point while this one is squared.
                    ptr_reg   <= ADDR_W'(i_reg + 1'b1);
                    state_reg <= S_Q_MX;
                end
                S_Q_MX:
                begin
                    state_reg <= S_Q_MY;
                end
                S_Q_MY:
                begin
                    acc_reg   <= {1'b0, p[63:0]};
                    state_reg <= S_Q_SUM;
                end
                S_Q_SUM:
                begin
                    best_reg   <= nb;
                    if (closer)
                    begin
                        best_d_reg <= sq_sum;
                    end
                    if (i_reg == point_count_reg - 1'b1)
                    begin
                        ptr_reg   <= nb;
                        state_reg <= S_ARC_WAIT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_Q_ABS;
                    end
                end
                S_ARC_WAIT:
                begin
                    state_reg <= S_ARC;
                end
                S_ARC:
                begin
                    base_reg <= rdata.arc;
                    if ({1'b0, best_reg} == point_count_reg - 1'b1)
                    begin
                        pick_reg  <= best_reg;
                        tx_reg    <= rx;
                        ty_reg    <= ry;
                        ax_reg    <= rmx;
                        ay_reg    <= rmy;
                        state_reg <= S_O_MX;
                    end
                    else
                    begin
                        i_reg     <= {1'b0, best_reg} + 1'b1;
                        ptr_reg   <= best_reg + 1'b1;
                        state_reg <= S_WALK_WAIT;
                    end
                end
                S_WALK_WAIT:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    // Reaching the last point without a hit selects the last point.
                    if (far || i_reg == point_count_reg - 1'b1)
                    begin
                        pick_reg  <= i_reg[ADDR_W-1:0];
                        tx_reg    <= rx;
                        ty_reg    <= ry;
                        ax_reg    <= rmx;
                        ay_reg    <= rmy;
                        state_reg <= S_O_MX;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        ptr_reg   <= ADDR_W'(i_reg + 1'b1);
                        state_reg <= S_WALK_WAIT;
                    end
                end
                S_O_MX:
                begin
                    state_reg <= S_O_MY;
                end
                S_O_MY:
                begin
                    acc_reg   <= {1'b0, p[63:0]};
                    state_reg <= S_O_SUM;
                end
                S_O_SUM:
                begin
                    if (sq_sum >= 65'h0_8000_0000)
                    begin
                        state_reg <= S_ATAN;
                    end
                    else
                    begin
                        deg_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_ATAN:
                begin
                    state_reg <= S_ATAN_WAIT;
                end
                S_ATAN_WAIT:
                begin
                    if (c_done)
                    begin
                        alpha_reg <= a2;
                        state_reg <= S_SIN;
                    end
                end
                S_SIN:
                begin
                    state_reg <= S_SIN_WAIT;
                end
                S_SIN_WAIT:
                begin
                    if (c_done)
                    begin
                        s_reg     <= c_y[32:0];
                        state_reg <= S_NUM;
                    end
                end
                S_NUM:
                begin
                    state_reg <= S_STEER;
                end
                S_STEER:
                begin
                    state_reg <= S_STEER_WAIT;
                end
                S_STEER_WAIT:
                begin
                    if (c_done)
                    begin
                        delta_reg <= c_z[32:0];
                        state_reg <= S_DEG;
                    end
                end
                S_DEG:
                begin
                    state_reg <= S_DEG_WAIT;
                end
                S_DEG_WAIT:
                begin
                    deg_reg   <= dclamp;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign target_x     = tx_reg;
    assign target_y     = ty_reg;
    assign target_index = 8'(pick_reg);
    assign steering_deg = deg_reg;
    assign no_path      = no_path_reg;

endmodule

// ===== src/ppst_path_mem.sv =====
module ppst_path_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ppst_pkg::ADDR_W-1:0] waddr,
    input  ppst_pkg::path_word_t        wdata,
    input  logic [ppst_pkg::ADDR_W-1:0] raddr,
    output ppst_pkg::path_word_t        rdata
);
    import ppst_pkg::*;

    path_word_t path_mem [MAX_POINTS];
    path_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            path_mem[waddr] <= wdata;
        end
        rdata_reg <= path_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ppst_mul.sv =====
module ppst_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);
    import ppst_pkg::*;

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ===== src/ppst_isqrt.sv =====
module ppst_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import ppst_pkg::*;

    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        take;

    assign trial = res_reg + bit_reg;
    assign take  = rem_reg >= trial;

    // One result bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= radicand;
                res_reg  <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (take)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ===== src/ppst_cordic.sv =====
module ppst_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               vec,
    input  logic signed [63:0] x0,
    input  logic signed [63:0] y0,
    input  logic signed [33:0] z0,
    output logic               done,
    output logic signed [63:0] y,
    output logic signed [33:0] z
);
    import ppst_pkg::*;

    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    logic signed [33:0] z_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               vec_reg;
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic signed [33:0] ang;
    logic               cw;

    assign sx  = y_reg >>> step_reg;
    assign sy  = x_reg >>> step_reg;
    assign ang = atan_step(int'(step_reg));
    // Vectoring drives y to zero, rotation drives z to zero.
    assign cw  = vec_reg ? (y_reg > 64'sd0) : (z_reg < 34'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                vec_reg  <= vec;
                step_reg <= '0;
                if (vec && x0 == 64'sd0 && y0 == 64'sd0)
                begin
                    x_reg    <= '0;
                    y_reg    <= '0;
                    z_reg    <= '0;
                    done_reg <= 1'b1;
                end
                else if (vec && x0 < 64'sd0)
                begin
                    z_reg    <= (y0 >= 64'sd0) ? PI_Q28 : -PI_Q28;
                    x_reg    <= -x0;
                    y_reg    <= -y0;
                    busy_reg <= 1'b1;
                end
                else
                begin
                    z_reg    <= vec ? 34'sd0 : z0;
                    x_reg    <= x0;
                    y_reg    <= y0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (cw)
                begin
                    x_reg <= x_reg + sx;
                    y_reg <= y_reg - sy;
                    z_reg <= z_reg + ang;
                end
                else
                begin
                    x_reg <= x_reg - sx;
                    y_reg <= y_reg + sy;
                    z_reg <= z_reg - ang;
                end
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

// ===== tb/sv/tb_pure_pursuit_steering_unit.sv =====
module tb_pure_pursuit_steering_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ppst_pkg::*;

    localparam longint PI_L     = 843314857;
    localparam longint HPI_L    = 421657428;
    localparam longint GAIN_L   = 652032874;
    localparam longint R2D_L    = 3754936;
    localparam longint LIMIT_L  = 5094;
    localparam int     TIMEOUT  = 4000000;

    typedef struct packed {
        logic [31:0] tx;
        logic [31:0] ty;
        logic [7:0]  idx;
        logic [13:0] deg;
        logic        nop;
    } steer_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic cmd = 1'b0;
    logic signed [31:0] point_x = '0, point_y = '0, car_x = '0, car_y = '0;
    logic point_last = 1'b0;
    logic signed [15:0] car_yaw = '0;
    logic done;
    logic signed [31:0] target_x, target_y;
    logic [7:0] target_index;
    logic signed [13:0] steering_deg;
    logic no_path;

    pure_pursuit_steering_unit dut (.*);

    always #2 clk = ~clk;

    // Predictor state.
    logic [31:0] mdl_x [MAX_POINTS];
    logic [31:0] mdl_y [MAX_POINTS];
    logic [31:0] mdl_arc [MAX_POINTS];
    int unsigned mdl_count, mdl_loading;
    longint unsigned mdl_look, mdl_wb;
    steer_result_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    int quiet_len = 0;

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [64:0] dist_sq(longint dx, longint dy);
        longint unsigned a = abs64(dx), b = abs64(dy);
        return {1'b0, a * a} + {1'b0, b * b};
    endfunction

    function automatic longint rot_angle(int i);
        return longint'(atan_step(i));
    endfunction

    function automatic longint vec_atan2(longint y, longint x);
        longint z = 0, sx, sy;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_L : -PI_L;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sx = sra(y, i);
            sy = sra(x, i);
            if (y > 0) begin
                x += sx; y -= sy; z += rot_angle(i);
            end
            else begin
                x -= sx; y += sy; z -= rot_angle(i);
            end
        end
        return z;
    endfunction

    function automatic longint rot_sin(longint a);
        longint x = GAIN_L, y = 0, sx, sy;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sx = sra(y, i);
            sy = sra(x, i);
            if (a >= 0) begin
                x -= sx; y += sy; a -= rot_angle(i);
            end
            else begin
                x += sx; y -= sy; a += rot_angle(i);
            end
        end
        return y;
    endfunction

    function automatic longint steer_angle(longint tx, longint ty, longint cx, longint cy,
                                           longint yaw);
        longint alpha, s, num, den, d, deg;
        alpha = vec_atan2(ty - cy, tx - cx) - yaw * 32768;
        if (alpha > PI_L) alpha -= 2 * PI_L;
        else if (alpha <= -PI_L) alpha += 2 * PI_L;
        if (alpha > HPI_L) alpha = PI_L - alpha;
        else if (alpha < -HPI_L) alpha = -PI_L - alpha;
        s = rot_sin(alpha);
        num = 2 * longint'(mdl_wb) * s;
        den = longint'(mdl_look) * (64'sd1 <<< 30);
        d = vec_atan2(num, den);
        deg = sra(d * R2D_L + (64'sd1 <<< 35), 36);
        if (deg > LIMIT_L) deg = LIMIT_L;
        if (deg < -LIMIT_L) deg = -LIMIT_L;
        return deg;
    endfunction

    function automatic void predict_load(logic [31:0] px, logic [31:0] py, logic last);
        longint dx, dy;
        longint unsigned ax, ay, d, sum;
        int unsigned k;
        if (mdl_loading == 0) mdl_count = 0;
        if (mdl_loading < MAX_POINTS) begin
            k = mdl_loading;
            mdl_x[k] = px;
            mdl_y[k] = py;
            if (k == 0) mdl_arc[k] = 0;
            else begin
                dx = longint'($signed(px)) - longint'($signed(mdl_x[k-1]));
                dy = longint'($signed(py)) - longint'($signed(mdl_y[k-1]));
                ax = abs64(dx);
                ay = abs64(dy);
                if (((ax >> 31) | (ay >> 31)) != 0) begin
                    ax >>= 1;
                    ay >>= 1;
                    d = int_sqrt(ax * ax + ay * ay) << 1;
                end
                else d = int_sqrt(ax * ax + ay * ay);
                sum = longint'(mdl_arc[k-1]) + d;
                mdl_arc[k] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
            mdl_loading++;
        end
        if (last) begin
            mdl_count = mdl_loading;
            mdl_loading = 0;
        end
    endfunction

    function automatic steer_result_t predict_query(logic [31:0] cxv, logic [31:0] cyv,
                                                    logic [15:0] yawv);
        steer_result_t r;
        longint cx, cy, tx, ty, deg;
        logic [64:0] best_d, dd;
        int unsigned best, pick;
        r = '0;
        if (mdl_count == 0) begin
            r.nop = 1'b1;
            return r;
        end
        cx = $signed(cxv);
        cy = $signed(cyv);
        best = 0;
        best_d = '0;
        for (int unsigned i = 0; i < mdl_count; i++) begin
            dd = dist_sq(longint'($signed(mdl_x[i])) - cx, longint'($signed(mdl_y[i])) - cy);
            if (i == 0 || dd < best_d) begin
                best = i;
                best_d = dd;
            end
        end
        pick = mdl_count - 1;
        for (int unsigned i = best; i < mdl_count; i++) begin
            if (32'(mdl_arc[i] - mdl_arc[best]) > mdl_look) begin
                pick = i;
                break;
            end
        end
        tx = $signed(mdl_x[pick]);
        ty = $signed(mdl_y[pick]);
        deg = 0;
        if (dist_sq(tx, ty) >= 65'h8000_0000)
            deg = steer_angle(tx, ty, cx, cy, longint'($signed(yawv)));
        r.tx = tx[31:0];
        r.ty = ty[31:0];
        r.idx = pick[7:0];
        r.deg = deg[13:0];
        return r;
    endfunction

    // Idle before an item, each further idle cycle with chance 38 in 100, except when quiet.
    task automatic idle_gap();
        while (quiet_len == 0 && $urandom_range(99) < 38) begin
            start <= 1'b0;
            @(posedge clk);
        end
        if (quiet_len > 0) quiet_len--;
    endtask

    task automatic send_item(logic c, logic [31:0] px, logic [31:0] py, logic last,
                             logic [31:0] cx, logic [31:0] cy, logic [15:0] yaw);
        idle_gap();
        start <= 1'b1;
        cmd <= c;
        point_x <= px;
        point_y <= py;
        point_last <= last;
        car_x <= cx;
        car_y <= cy;
        car_yaw <= yaw;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (c == CMD_LOAD) predict_load(px, py, last);
        else pending_results.insert(pending_results.size(), predict_query(cx, cy, yaw));
    endtask

    task automatic load_point(logic [31:0] px, logic [31:0] py, logic last);
        send_item(CMD_LOAD, px, py, last, $urandom, $urandom, 16'($urandom));
    endtask

    task automatic query(logic [31:0] cx, logic [31:0] cy, logic [15:0] yaw);
        send_item(CMD_QUERY, $urandom, $urandom, 1'($urandom), cx, cy, yaw);
    endtask

    // Loads leave no result behind, so wait out the longest point time too.
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LOOKAHEAD) mdl_look = value[22:0];
        else mdl_wb = value[19:0];
    endtask

    always @(posedge clk) begin
        steer_result_t exp_r;
        cycles <= cycles + 1;
        if (cycles > TIMEOUT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else begin
                exp_r = pending_results.pop_front();
                if (target_x !== exp_r.tx) begin
                    $error("target_x exp %h got %h", exp_r.tx, target_x); errors++;
                end
                if (target_y !== exp_r.ty) begin
                    $error("target_y exp %h got %h", exp_r.ty, target_y); errors++;
                end
                if (target_index !== exp_r.idx) begin
                    $error("target_index exp %0d got %0d", exp_r.idx, target_index); errors++;
                end
                if (steering_deg !== exp_r.deg) begin
                    $error("steering_deg exp %h got %h", exp_r.deg, steering_deg); errors++;
                end
                if (no_path !== exp_r.nop) begin
                    $error("no_path exp %b got %b", exp_r.nop, no_path); errors++;
                end
            end
        end
    end

    function automatic logic [31:0] small_coord();
        return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endfunction

    task automatic test_directed();
        query(32'h0, 32'h0, 16'h0);
        load_point(32'h0001_0000, 32'h0, 1'b0);
        query(32'h0, 32'h0, 16'h0);
        load_point(32'h0002_0000, 32'h0001_0000, 1'b0);
        load_point(32'h0005_0000, 32'h0003_0000, 1'b0);
        load_point(32'h0009_0000, 32'hFFFE_0000, 1'b1);
        query(32'h0, 32'h0, 16'h0);
        query(32'h0004_0000, 32'h0003_0000, 16'h7FFF);
        query(32'hFFF0_0000, 32'h0010_0000, 16'h8000);
        query(32'h0009_0000, 32'hFFFE_0000, 16'h1922);
        // A single point close to the origin gives zero steering.
        load_point(32'h0000_4000, 32'h0000_4000, 1'b1);
        query(32'h0010_0000, 32'h0, 16'h0);
        // Extreme coordinates exercise the halved arc step and 65-bit distances.
        load_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        load_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        load_point(32'h8000_0000, 32'h8000_0000, 1'b1);
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0);
        query(32'h8000_0000, 32'h8000_0000, 16'h4000);
        query(32'h8000_0000, 32'h8000_0000, 16'hC000);
        drain();
    endtask

    task automatic test_overflow_path();
        for (int i = 0; i < MAX_POINTS + 4; i++)
            load_point(32'(i << 15), 32'(i << 14), i == MAX_POINTS + 3);
        query(32'h0, 32'h0, 16'h0);
        query(32'h0080_0000, 32'h0040_0000, 16'h0);
        drain();
    endtask

    task automatic test_registers();
        write_reg(REG_LOOKAHEAD, 32'd65536);
        write_reg(REG_WHEELBASE, 32'd0);
        for (int i = 0; i < 6; i++) load_point(32'(i << 16), 32'(i << 15), i == 5);
        query(32'h0, 32'h0001_0000, 16'h0);
        drain();
        write_reg(REG_WHEELBASE, 32'd655360);
        write_reg(REG_LOOKAHEAD, 32'd4194304);
        query(32'h0, 32'h0001_0000, 16'h0);
        drain();
        write_reg(REG_LOOKAHEAD, 32'd0);
        query(32'h0, 32'h0001_0000, 16'h2000);
        query(32'h0005_0000, 32'h0002_8000, 16'h0);
        drain();
        write_reg(REG_LOOKAHEAD, 32'hFFFF_FFFF);
        write_reg(REG_WHEELBASE, 32'hFFFF_FFFF);
        query(32'h0, 32'h0001_0000, 16'h0);
        drain();
    endtask

    task automatic test_random(int n_items);
        int sent = 0;
        int plen;
        while (sent < n_items) begin
            if (sent > n_items / 2 && sent < n_items / 2 + 20) quiet_len = 60;
            if ($urandom_range(9) < 8) begin
                plen = $urandom_range(1, 12);
                for (int i = 0; i < plen; i++) begin
                    load_point(small_coord(), small_coord(), i == plen - 1);
                    sent++;
                end
            end
            else begin
                load_point($urandom, $urandom, 1'($urandom_range(1)));
                sent++;
            end
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(9) == 0) query($urandom, $urandom, 16'($urandom));
                else query(small_coord(), small_coord(), 16'($urandom));
                sent++;
            end
            if ($urandom_range(15) == 0) begin
                drain();
                write_reg(REG_LOOKAHEAD, $urandom_range(65536, 4194304));
                write_reg(REG_WHEELBASE, $urandom_range(0, 655360));
            end
        end
        drain();
    endtask

    initial begin
        mdl_count = 0;
        mdl_loading = 0;
        mdl_look = LOOKAHEAD_RESET;
        mdl_wb = WHEELBASE_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow_path();
        test_registers();
        write_reg(REG_LOOKAHEAD, LOOKAHEAD_RESET);
        write_reg(REG_WHEELBASE, WHEELBASE_RESET);
        test_random(700);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
